// ===== rtl/core/entity_delta_filter_assert.svh =====
// ---------------------------------------------------------------------------
// entity_delta_filter assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ---------------------------------------------------------------------------
`ifndef ENTITY_DELTA_FILTER_ASSERT_SVH
`define ENTITY_DELTA_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define EDF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/edf_pkg.sv =====
// ---------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the entity delta filter.
// ---------------------------------------------------------------------------
package edf_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_CHECK = 2'd2;

	localparam logic [15:0] INDEX_MAX = 16'hFFFF;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] rot_0;
		logic [31:0] rot_1;
		logic [31:0] rot_2;
		logic [31:0] rot_3;
		logic [15:0] health;
		logic [31:0] stamp;
		logic [7:0]  flag_bits;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic done;
		logic changed;
	} scan_res_t;

endpackage

// ===== rtl/core/edf_ram.sv =====
// ---------------------------------------------------------------------------
// edf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module edf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/edf_scan.sv =====
// ---------------------------------------------------------------------------
// edf_scan
// Walks the record table one entry a cycle and compares each read against
// the current record; stops at the first id hit or the last stored entry.
// ---------------------------------------------------------------------------
module edf_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [edf_pkg::CNT_W-1:0]  count,
	input  edf_pkg::rec_t              key,
	input  edf_pkg::rec_t              rd_data,
	output edf_pkg::rd_req_t           rd_req,
	output edf_pkg::scan_res_t         res
);

	logic                      active_q;
	logic [edf_pkg::CNT_W-1:0] idx_q;
	logic                      valid_s1;
	logic [edf_pkg::CNT_W-1:0] idx_s1;
	logic                      id_hit;
	logic                      last;

	// Issue a read while entries remain.
	always_comb begin
		rd_req.en   = active_q && (idx_q < count);
		rd_req.addr = idx_q[edf_pkg::ADDR_W-1:0];
	end

	// Compare stage lines up with the registered RAM data.
	always_comb begin
		id_hit      = (rd_data.id == key.id);
		last        = (idx_s1 == (count - edf_pkg::CNT_W'(1)));
		res.done    = valid_s1 && (id_hit || last);
		res.changed = !(id_hit && (rd_data == key));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (go) begin
				active_q <= 1'b1;
			end else if (res.done) begin
				active_q <= 1'b0;
			end
			// drop a read that was issued alongside the final compare
			valid_s1 <= rd_req.en && !res.done;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			idx_q <= '0;
		end else if (rd_req.en) begin
			idx_q <= idx_q + edf_pkg::CNT_W'(1);
		end
		idx_s1 <= idx_q;
	end

endmodule

// ===== rtl/core/entity_delta_filter.sv =====
// ---------------------------------------------------------------------------
// entity_delta_filter
// Filters current-snapshot entity records against a stored previous snapshot.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low; mode
//   selects clear (0), load of one previous record (1) or check of a current
//   record (2). Mode 3 is ignored.
//   Clear and load finish at the accepting edge; busy stays low and the next
//   transaction may follow in the very next cycle. A load into a full table
//   is dropped.
//   A check of a non-empty table raises busy and scans it from entry 0, one
//   entry a cycle through the single read port of the record RAM, until the
//   first entry with the same id or the last stored entry (entry n-1 with n
//   stored entries); the result strobe is registered from the final compare.
//   With an empty table busy stays low and the result follows in the cycle
//   after acceptance.
//   A result (record changed or new) is shown for exactly one cycle with
//   strobe high; record_index is its saturating place in the output stream.
//   The receiver cannot stall: the strobe cycle is not held off.
//   Reset empties the table (fill count zero) and zeroes the output counter;
//   the RAM contents are not cleared, entries above the fill count are never
//   read.
// ---------------------------------------------------------------------------
module entity_delta_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] rec_id,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] rot_0,
	input  logic [31:0] rot_1,
	input  logic [31:0] rot_2,
	input  logic [31:0] rot_3,
	input  logic [15:0] health,
	input  logic [31:0] stamp,
	input  logic [7:0]  flag_bits,
	output logic        strobe,
	output logic [15:0] record_index,
	output logic [31:0] out_id,
	output logic [31:0] out_pos_x,
	output logic [31:0] out_pos_y,
	output logic [31:0] out_pos_z,
	output logic [31:0] out_rot_0,
	output logic [31:0] out_rot_1,
	output logic [31:0] out_rot_2,
	output logic [31:0] out_rot_3,
	output logic [15:0] out_health,
	output logic [31:0] out_stamp,
	output logic [7:0]  out_flag_bits
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                    state_q;
	logic [edf_pkg::CNT_W-1:0] count_q;
	logic [15:0]               emitted_q;
	logic [15:0]               index_q;
	logic                      strobe_q;
	edf_pkg::rec_t             cur_q;
	edf_pkg::rec_t             in_rec;
	edf_pkg::rec_t             rd_data;
	edf_pkg::rd_req_t          rd_req;
	edf_pkg::scan_res_t        scan_res;

	logic acc;
	logic do_clear;
	logic do_load;
	logic do_check;
	logic scan_go;
	logic emit;

	// Gather the input ports into one record.
	always_comb begin
		in_rec.id        = rec_id;
		in_rec.pos_x     = pos_x;
		in_rec.pos_y     = pos_y;
		in_rec.pos_z     = pos_z;
		in_rec.rot_0     = rot_0;
		in_rec.rot_1     = rot_1;
		in_rec.rot_2     = rot_2;
		in_rec.rot_3     = rot_3;
		in_rec.health    = health;
		in_rec.stamp     = stamp;
		in_rec.flag_bits = flag_bits;
	end

	assign busy = (state_q != ST_IDLE);
	assign acc  = start && !busy;

	// Decode the accepted transaction.
	always_comb begin
		do_clear = 1'b0;
		do_load  = 1'b0;
		do_check = 1'b0;
		unique case (mode)
			edf_pkg::MODE_CLEAR: do_clear = acc;
			edf_pkg::MODE_LOAD:  do_load  = acc;
			edf_pkg::MODE_CHECK: do_check = acc;
			default: ;
		endcase
	end

	// An empty table means no previous snapshot: emit straight away.
	assign scan_go = do_check && (count_q != '0);
	assign emit    = (do_check && (count_q == '0)) ||
	                 (scan_res.done && scan_res.changed);

	// Record table: append at the fill count, drop when full.
	edf_ram #(
		.WIDTH (edf_pkg::REC_W),
		.DEPTH (edf_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_load && (count_q < edf_pkg::CNT_W'(edf_pkg::TABLE_DEPTH))),
		.waddr (count_q[edf_pkg::ADDR_W-1:0]),
		.wdata (in_rec),
		.re    (rd_req.en),
		.raddr (rd_req.addr),
		.rdata (rd_data)
	);

	edf_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (scan_go),
		.count   (count_q),
		.key     (cur_q),
		.rd_data (rd_data),
		.rd_req  (rd_req),
		.res     (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			emitted_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= emit;
			unique case (state_q)
				ST_IDLE: begin
					if (scan_go) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (do_clear) begin
				count_q   <= '0;
				emitted_q <= '0;
			end else begin
				if (do_load && (count_q < edf_pkg::CNT_W'(edf_pkg::TABLE_DEPTH))) begin
					count_q <= count_q + edf_pkg::CNT_W'(1);
				end
				// hold the counter once it saturates
				if (emit && (emitted_q != edf_pkg::INDEX_MAX)) begin
					emitted_q <= emitted_q + 16'd1;
				end
			end
		end
	end

	// Payload registers: current record and the index of the emitted one.
	always_ff @(posedge clk) begin
		if (do_check) begin
			cur_q <= in_rec;
		end
		if (emit) begin
			index_q <= emitted_q;
		end
	end

	assign strobe        = strobe_q;
	assign record_index  = index_q;
	assign out_id        = cur_q.id;
	assign out_pos_x     = cur_q.pos_x;
	assign out_pos_y     = cur_q.pos_y;
	assign out_pos_z     = cur_q.pos_z;
	assign out_rot_0     = cur_q.rot_0;
	assign out_rot_1     = cur_q.rot_1;
	assign out_rot_2     = cur_q.rot_2;
	assign out_rot_3     = cur_q.rot_3;
	assign out_health    = cur_q.health;
	assign out_stamp     = cur_q.stamp;
	assign out_flag_bits = cur_q.flag_bits;

endmodule

// ===== rtl/core/edf_chk.sv =====
// ---------------------------------------------------------------------------
// edf_chk
// Port-level checks of the entity delta filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "entity_delta_filter_assert.svh"

module edf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  mode,
	input logic        strobe,
	input logic [15:0] record_index
);

	logic take_check;
	logic take_other;

	assign take_check = start && !busy && (mode == edf_pkg::MODE_CHECK);
	assign take_other = start && !busy && (mode != edf_pkg::MODE_CHECK);

	// A result appears only when the scan has ended.
	`EDF_ASSERT_SAME(a_strobe_idle, strobe, !busy, "result shown while busy")

	// A result follows a check transaction or the end of a scan.
	`EDF_ASSERT_SAME(a_strobe_cause, strobe, $past(busy) || $past(take_check), "result without a check")

	// Clear and load never produce a result.
	`EDF_ASSERT_NEXT(a_no_result, take_other, !strobe, "result after clear or load")

	// An emitted record carries a defined index.
	`EDF_ASSERT_SAME(a_index_known, strobe, !$isunknown(record_index), "undefined record_index")

	// Busy rises only after a check is taken.
	`EDF_ASSERT_SAME(a_busy_rise, $rose(busy), $past(take_check), "busy without a check")

endmodule

bind entity_delta_filter edf_chk u_edf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.mode         (mode),
	.strobe       (strobe),
	.record_index (record_index)
);
